// File: rtl/cawm_pkg.sv
// ----------------------------------------------------------------------------
// cawm_pkg
// Shared types and constants for the command/acknowledge window matcher.
// ----------------------------------------------------------------------------
package cawm_pkg;

	localparam int ACK_LENGTH     = 19;
	localparam int COMMAND_LENGTH = 20;
	localparam int TABLE_MAX      = 32;

	localparam int FILL_W    = $clog2(ACK_LENGTH + 1);
	localparam int CMD_IDX_W = (COMMAND_LENGTH > 1) ? $clog2(COMMAND_LENGTH) : 1;
	localparam int TBL_IDX_W = $clog2(TABLE_MAX);

	localparam logic [7:0] TIMEOUT_RESET = 8'd47;

	localparam logic [1:0] OP_START   = 2'd0;
	localparam logic [1:0] OP_RX_BYTE = 2'd1;
	localparam logic [1:0] OP_TICK    = 2'd2;
	localparam logic [1:0] OP_OVERRUN = 2'd3;

	localparam logic [1:0] OUTCOME_NONE    = 2'd0;
	localparam logic [1:0] OUTCOME_ACK     = 2'd1;
	localparam logic [1:0] OUTCOME_TIMEOUT = 2'd2;

	localparam logic [7:0] CMD_FRAME [0:TABLE_MAX-1] = '{
		0: 8'h7E, 1: 8'h00, 2: 8'h10, 3: 8'h17, 4: 8'h01, 5: 8'h00, 6: 8'h13,
		7: 8'hA2, 8: 8'h00, 9: 8'h41, 10: 8'hA2, 11: 8'h2D, 12: 8'hDC,
		13: 8'hFF, 14: 8'hFE, 15: 8'h02, 16: 8'h44, 17: 8'h31, 18: 8'h05,
		19: 8'hCD, default: 8'h00
	};

	localparam logic [7:0] ACK_FRAME [0:TABLE_MAX-1] = '{
		0: 8'h7E, 1: 8'h00, 2: 8'h0F, 3: 8'h97, 4: 8'h01, 5: 8'h00, 6: 8'h13,
		7: 8'hA2, 8: 8'h00, 9: 8'h41, 10: 8'hA2, 11: 8'h2D, 12: 8'hDC,
		13: 8'hFF, 14: 8'hFE, 15: 8'h44, 16: 8'h31, 17: 8'h00, 18: 8'h54,
		default: 8'h00
	};

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       tx_valid;
		logic       last;
		logic       radio_awake;
		logic       uart_restart;
		logic [1:0] outcome;
	} out_item_t;

	// one classified item handed from front to back
	typedef struct packed {
		logic       is_frame;
		logic       ends;
		logic       awake;
		logic       restart;
		logic [1:0] outcome;
	} job_t;

endpackage

// File: rtl/cawm_front.sv
// ----------------------------------------------------------------------------
// cawm_front
// Accepts items, tracks armed state, ack window and timeout, emits one job.
// ----------------------------------------------------------------------------
module cawm_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  cawm_pkg::in_item_t in_item,
	output logic               job_valid,
	input  logic               job_ready,
	output cawm_pkg::job_t     job
);
	import cawm_pkg::*;

	logic [7:0]        timeout_q;
	logic [7:0]        window_q [0:ACK_LENGTH-1];
	logic [7:0]        win_nxt  [0:ACK_LENGTH-1];
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_nxt;
	logic [7:0]        period_q;
	logic [7:0]        period_nxt;
	logic              armed_q;
	logic              match;
	logic              accept;

	assign in_ready  = job_ready;
	assign job_valid = in_valid;
	assign accept    = in_valid && job_ready;

	always_comb begin
		for (int i = 0; i < ACK_LENGTH - 1; i++) begin
			win_nxt[i] = window_q[i + 1];
		end
		win_nxt[ACK_LENGTH - 1] = in_item.rx_byte;
	end

	assign fill_nxt   = (fill_q < FILL_W'(ACK_LENGTH)) ? fill_q + 1'b1 : fill_q;
	assign period_nxt = (period_q == 8'hFF) ? period_q : period_q + 8'd1;

	always_comb begin
		match = (fill_nxt >= FILL_W'(ACK_LENGTH));
		for (int i = 0; i < ACK_LENGTH; i++) begin
			if (win_nxt[i] != ACK_FRAME[i]) begin
				match = 1'b0;
			end
		end
	end

	always_comb begin
		job = '{is_frame: 1'b0, ends: 1'b0, awake: 1'b0, restart: 1'b0,
			outcome: OUTCOME_NONE};
		if (in_item.opcode == OP_START) begin
			job.is_frame = 1'b1;
			job.ends     = (timeout_q == 8'd0);
		end else if (armed_q) begin
			job.awake = 1'b1;
			case (in_item.opcode)
				OP_RX_BYTE: begin
					if (match) begin
						job.awake   = 1'b0;
						job.outcome = OUTCOME_ACK;
					end
				end
				OP_TICK: begin
					if (period_nxt >= timeout_q) begin
						job.awake   = 1'b0;
						job.outcome = OUTCOME_TIMEOUT;
					end
				end
				OP_OVERRUN: job.restart = 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			fill_q    <= '0;
			period_q  <= '0;
			armed_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (accept) begin
				if (in_item.opcode == OP_START) begin
					fill_q   <= '0;
					period_q <= '0;
					armed_q  <= (timeout_q != 8'd0);
				end else if (armed_q) begin
					case (in_item.opcode)
						OP_RX_BYTE: begin
							fill_q <= fill_nxt;
							if (match) begin
								armed_q <= 1'b0;
							end
						end
						OP_TICK: begin
							period_q <= period_nxt;
							if (period_nxt >= timeout_q) begin
								armed_q <= 1'b0;
							end
						end
						default: ;
					endcase
				end
			end
		end
	end

	// window contents only count once fill reaches the ack length
	always_ff @(posedge clk) begin
		if (accept && armed_q && in_item.opcode == OP_RX_BYTE) begin
			for (int i = 0; i < ACK_LENGTH; i++) begin
				window_q[i] <= win_nxt[i];
			end
		end
	end

endmodule

// File: rtl/cawm_queue.sv
// ----------------------------------------------------------------------------
// cawm_queue
// Four-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module cawm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  cawm_pkg::job_t push_job,
	output logic           pop_valid,
	input  logic           pop_ready,
	output cawm_pkg::job_t pop_job
);
	import cawm_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	job_t             mem_q [0:DEPTH-1];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != (PTR_W + 1)'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// File: rtl/cawm_back.sv
// ----------------------------------------------------------------------------
// cawm_back
// Expands jobs into result items: the command frame or one status item.
// ----------------------------------------------------------------------------
module cawm_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	output logic                job_ready,
	input  cawm_pkg::job_t      job,
	output logic                out_valid,
	input  logic                out_ready,
	output cawm_pkg::out_item_t out_item
);
	import cawm_pkg::*;

	localparam logic [CMD_IDX_W-1:0] LAST_IDX = CMD_IDX_W'(COMMAND_LENGTH - 1);

	out_item_t            out_q;
	logic                 out_valid_q;
	logic                 busy_q;
	logic                 ends_q;
	logic [CMD_IDX_W-1:0] idx_q;
	logic [CMD_IDX_W-1:0] cur_idx;
	logic                 cur_ends;
	logic                 load;
	logic                 fin;
	out_item_t            frame_item;

	assign load      = !out_valid_q || out_ready;
	assign job_ready = load && !busy_q;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// first frame byte comes straight from the job, the rest from the counter
	assign cur_idx  = busy_q ? idx_q : '0;
	assign cur_ends = busy_q ? ends_q : job.ends;
	assign fin      = (cur_idx == LAST_IDX);

	always_comb begin
		frame_item.tx_byte      = CMD_FRAME[TBL_IDX_W'(cur_idx)];
		frame_item.tx_valid     = 1'b1;
		frame_item.last         = fin;
		frame_item.radio_awake  = !(fin && cur_ends);
		frame_item.uart_restart = 1'b0;
		frame_item.outcome      = (fin && cur_ends) ? OUTCOME_TIMEOUT : OUTCOME_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			busy_q      <= 1'b0;
			ends_q      <= 1'b0;
			idx_q       <= '0;
			out_q       <= '0;
		end else if (load) begin
			if (busy_q) begin
				out_q       <= frame_item;
				out_valid_q <= 1'b1;
				idx_q       <= idx_q + 1'b1;
				if (fin) begin
					busy_q <= 1'b0;
				end
			end else if (job_valid) begin
				out_valid_q <= 1'b1;
				if (job.is_frame) begin
					out_q  <= frame_item;
					ends_q <= job.ends;
					idx_q  <= CMD_IDX_W'(1);
					busy_q <= !fin;
				end else begin
					out_q.tx_byte      <= 8'h00;
					out_q.tx_valid     <= 1'b0;
					out_q.last         <= 1'b1;
					out_q.radio_awake  <= job.awake;
					out_q.uart_restart <= job.restart;
					out_q.outcome      <= job.outcome;
				end
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/command_ack_window_matcher_top.sv
// ----------------------------------------------------------------------------
// command_ack_window_matcher_top
// Sends the radio command frame and watches received bytes for the ack frame.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_item) takes one item per cycle while the
// queue has room: start, received byte, timer period tick or receive overrun.
// The front part updates the armed flag, the 19-byte receive window and the
// period count at accept, then queues a job (four entries) for the back part.
// Output channel (out_valid/out_ready/out_item) gives one result per cycle while
// out_ready is high: a start yields the 20 command frame bytes, else one status
// item. An accepted item is registered in a queue entry, then in the back part's
// output register. Sustained rate is one item per cycle for non-start items
// while out_ready is high; a start holds the output for its 20 frame bytes.
// cfg_we/cfg_wdata write the timeout period count; write only while idle.
// Reset clears armed state and the queue and loads a timeout of 47 periods.
// When the receiver stalls, the output register holds, the queue fills and
// in_ready drops once all four entries are taken.
// ----------------------------------------------------------------------------
module command_ack_window_matcher_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  cawm_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output cawm_pkg::out_item_t out_item
);
	import cawm_pkg::*;

	logic fq_valid;
	logic fq_ready;
	job_t fq_job;
	logic qb_valid;
	logic qb_ready;
	job_t qb_job;

	cawm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.job_valid (fq_valid),
		.job_ready (fq_ready),
		.job       (fq_job)
	);

	cawm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_job   (fq_job),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_job    (qb_job)
	);

	cawm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (qb_valid),
		.job_ready (qb_ready),
		.job       (qb_job),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// File: dv/command_ack_window_matcher_top_tb.sv
// ----------------------------------------------------------------------------
// command_ack_window_matcher_top_tb
// Checks the command frame, the ack window match, the period timeout and the
// overrun restart of the matcher against a cycle-free prediction. Directed
// items cover idle, re-arm and timeout edges, one long output stall and one
// drain pause; random exchanges send mostly well-formed ack frames with noise,
// broken frames and timeouts, under random gaps and stalls.
// ----------------------------------------------------------------------------
module command_ack_window_matcher_top_tb;

	import cawm_pkg::*;

	localparam int RANDOM_ITEMS = 190;
	localparam int DRAIN_CYCLES = 6;
	localparam int RUN_LIMIT    = 20_000_000;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      cfg_we;
	logic [7:0] cfg_wdata;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;

	// prediction state
	logic [7:0] rx_window [ACK_LENGTH];
	int         rx_fill;
	int         tick_count;
	bit         link_armed;
	logic [7:0] timeout_cfg;
	out_item_t  pending_results [$];

	bit sender_idle;
	bit receiver_idle;
	int rx_holdoff_req;

	int items_taken;
	int active_items;
	int results_seen;
	int acks_predicted;
	int timeouts_predicted;
	int restarts_predicted;
	int error_count;

	command_ack_window_matcher_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#(RUN_LIMIT);
		$display("run limit reached with %0d results outstanding", pending_results.size());
		$display("status: fail");
		$finish;
	end

	// Push the results of one accepted item; return 0 when the block ignores it.
	function automatic bit predict_results(in_item_t it);
		out_item_t r;
		bit ends;
		bit hit;
		r = '0;
		r.last = 1'b1;
		items_taken++;
		if (it.opcode == OP_START) begin
			ends = (timeout_cfg == 8'd0);
			for (int i = 0; i < ACK_LENGTH; i++)
				rx_window[i] = 8'h00;
			rx_fill = 0;
			tick_count = 0;
			link_armed = !ends;
			if (ends)
				timeouts_predicted++;
			for (int i = 0; i < COMMAND_LENGTH; i++) begin
				r.tx_byte = CMD_FRAME[i];
				r.tx_valid = 1'b1;
				r.last = (i == COMMAND_LENGTH - 1);
				r.radio_awake = !(r.last && ends);
				r.outcome = (r.last && ends) ? OUTCOME_TIMEOUT : OUTCOME_NONE;
				pending_results.push_back(r);
			end
			return 1'b1;
		end
		if (!link_armed) begin
			pending_results.push_back(r);
			return 1'b0;
		end
		r.radio_awake = 1'b1;
		r.outcome = OUTCOME_NONE;
		case (it.opcode)
			OP_RX_BYTE: begin
				for (int i = 0; i < ACK_LENGTH - 1; i++)
					rx_window[i] = rx_window[i + 1];
				rx_window[ACK_LENGTH - 1] = it.rx_byte;
				if (rx_fill < ACK_LENGTH)
					rx_fill++;
				hit = (rx_fill >= ACK_LENGTH);
				for (int i = 0; i < ACK_LENGTH; i++)
					if (rx_window[i] != ACK_FRAME[i])
						hit = 1'b0;
				if (hit) begin
					link_armed = 1'b0;
					r.radio_awake = 1'b0;
					r.outcome = OUTCOME_ACK;
					acks_predicted++;
				end
			end
			OP_TICK: begin
				if (tick_count < 255)
					tick_count++;
				if (tick_count >= timeout_cfg) begin
					link_armed = 1'b0;
					r.radio_awake = 1'b0;
					r.outcome = OUTCOME_TIMEOUT;
					timeouts_predicted++;
				end
			end
			default: begin
				r.uart_restart = 1'b1;
				restarts_predicted++;
			end
		endcase
		pending_results.push_back(r);
		return 1'b1;
	endfunction

	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				if (error_count < 10)
					$display("result %0d arrived with nothing expected: %h",
						results_seen, out_item);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_item.tx_byte !== want.tx_byte || out_item.tx_valid !== want.tx_valid
						|| out_item.last !== want.last
						|| out_item.radio_awake !== want.radio_awake
						|| out_item.uart_restart !== want.uart_restart
						|| out_item.outcome !== want.outcome) begin
					if (error_count < 10) begin
						$display("result %0d mismatch: expected byte=%h valid=%b last=%b awake=%b",
							results_seen, want.tx_byte, want.tx_valid, want.last,
							want.radio_awake);
						$display("  restart=%b outcome=%0d, got byte=%h valid=%b last=%b",
							want.uart_restart, want.outcome, out_item.tx_byte,
							out_item.tx_valid, out_item.last);
						$display("  awake=%b restart=%b outcome=%0d", out_item.radio_awake,
							out_item.uart_restart, out_item.outcome);
					end
					error_count++;
				end
			end
		end
	end

	// Output side: before each result, stall for a holdoff request or, if idle, a random number of cycles.
	initial begin : result_receiver
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_holdoff_req > 0) begin
				stall = rx_holdoff_req;
				rx_holdoff_req = 0;
			end else if (receiver_idle) begin
				stall = $urandom_range(0, 8);
			end else begin
				stall = 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_item(input logic [1:0] op, input logic [7:0] data);
		in_item_t it;
		int gap;
		it.opcode = op;
		it.rx_byte = data;
		gap = sender_idle ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_item <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		if (predict_results(it))
			active_items++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [7:0] periods);
		wait_drained();
		cfg_wdata <= periods;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		timeout_cfg = periods;
	endtask

	// Send the ack frame, optionally with one flipped bit and stray ticks/overruns.
	task automatic send_ack_frame(input int corrupt_at, input bit with_noise);
		logic [7:0] b;
		for (int i = 0; i < ACK_LENGTH; i++) begin
			if (with_noise && $urandom_range(0, 7) == 0)
				send_item(2'($urandom_range(OP_TICK, OP_OVERRUN)),
					8'($urandom_range(0, 255)));
			b = ACK_FRAME[i];
			if (i == corrupt_at)
				b = b ^ (8'h01 << $urandom_range(0, 7));
			send_item(OP_RX_BYTE, b);
		end
	endtask

	task automatic test_idle_items();
		sender_idle = 1'b1;
		receiver_idle = 1'b1;
		send_item(OP_RX_BYTE, 8'hFF);
		send_item(OP_TICK, 8'h00);
		send_item(OP_OVERRUN, 8'hA5);
	endtask

	task automatic test_rearm_and_ack();
		write_timeout(8'd255);
		send_item(OP_START, 8'h00);
		send_item(OP_OVERRUN, 8'h5A);
		send_item(OP_TICK, 8'hFF);
		send_item(OP_RX_BYTE, 8'h00);
		send_item(OP_RX_BYTE, 8'hFF);
		// restart mid-exchange: window and counts clear, frame goes out again
		send_item(OP_START, 8'hFF);
		send_ack_frame(-1, 1'b0);
		send_item(OP_RX_BYTE, ACK_FRAME[0]);
	endtask

	task automatic test_timeout_edges();
		write_timeout(8'd0);
		send_item(OP_START, 8'h3C);
		send_item(OP_TICK, 8'h00);
		write_timeout(8'd1);
		send_item(OP_START, 8'hC3);
		send_item(OP_TICK, 8'h00);
		write_timeout(TIMEOUT_RESET);
	endtask

	task automatic test_backpressure();
		sender_idle = 1'b0;
		receiver_idle = 1'b0;
		rx_holdoff_req = 120;
		repeat (3) send_item(OP_START, 8'($urandom_range(0, 255)));
		for (int i = 0; i < 6; i++)
			send_item(OP_RX_BYTE, ACK_FRAME[i]);
		send_item(OP_OVERRUN, 8'($urandom_range(0, 255)));
		wait_drained();
	endtask

	task automatic test_pause_until_drained();
		sender_idle = 1'b1;
		receiver_idle = 1'b1;
		send_item(OP_START, 8'($urandom_range(0, 255)));
		for (int i = 0; i < 9; i++)
			send_item(OP_RX_BYTE, ACK_FRAME[i]);
		wait_drained();
		for (int i = 9; i < ACK_LENGTH; i++)
			send_item(OP_RX_BYTE, ACK_FRAME[i]);
	endtask

	task automatic run_random_exchange();
		int kind;
		int n;
		kind = $urandom_range(0, 9);
		if (kind <= 5) begin
			send_item(OP_START, 8'($urandom_range(0, 255)));
			n = $urandom_range(0, 5);
			repeat (n) send_item(2'($urandom_range(OP_RX_BYTE, OP_OVERRUN)),
				8'($urandom_range(0, 255)));
			send_ack_frame(-1, 1'b1);
			n = $urandom_range(0, 2);
			repeat (n) send_item(2'($urandom_range(OP_RX_BYTE, OP_OVERRUN)),
				8'($urandom_range(0, 255)));
		end else if (kind == 6) begin
			send_item(OP_START, 8'($urandom_range(0, 255)));
			send_ack_frame($urandom_range(0, ACK_LENGTH - 1), 1'b1);
		end else if (kind == 7) begin
			send_item(OP_START, 8'($urandom_range(0, 255)));
			n = (timeout_cfg < 40) ? timeout_cfg + 1 : 40;
			repeat (n) send_item(OP_TICK, 8'($urandom_range(0, 255)));
		end else if (kind == 8) begin
			n = $urandom_range(1, 8);
			repeat (n) send_item(2'($urandom_range(OP_START, OP_OVERRUN)),
				8'($urandom_range(0, 255)));
		end else begin
			send_item(OP_START, 8'($urandom_range(0, 255)));
			n = $urandom_range(1, ACK_LENGTH - 1);
			for (int i = 0; i < n; i++)
				send_item(OP_RX_BYTE, ACK_FRAME[i]);
			send_item(OP_START, 8'($urandom_range(0, 255)));
			send_ack_frame(-1, 1'b0);
		end
	endtask

	task automatic test_random_traffic();
		int stop_at;
		stop_at = items_taken + RANDOM_ITEMS;
		while (items_taken < stop_at) begin
			case ($urandom_range(0, 5))
				0: write_timeout(8'd0);
				1: write_timeout(8'd255);
				2: write_timeout(TIMEOUT_RESET);
				3: write_timeout(8'd1);
				default: write_timeout(8'($urandom_range(2, 40)));
			endcase
			sender_idle = ($urandom_range(0, 3) != 0);
			receiver_idle = ($urandom_range(0, 3) != 0);
			repeat (2) run_random_exchange();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'h00;
		in_valid = 1'b0;
		in_item = '0;
		timeout_cfg = TIMEOUT_RESET;
		for (int i = 0; i < ACK_LENGTH; i++)
			rx_window[i] = 8'h00;
		rx_fill = 0;
		tick_count = 0;
		link_armed = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_items();
		test_rearm_and_ack();
		test_timeout_edges();
		test_backpressure();
		test_pause_until_drained();
		test_random_traffic();

		wait_drained();
		$display("covered %0d items (%0d ignored while idle), %0d results checked",
			items_taken, items_taken - active_items, results_seen);
		$display("ack matches %0d, timeouts %0d, receiver restarts %0d, errors %0d",
			acks_predicted, timeouts_predicted, restarts_predicted, error_count);
		if (error_count == 0 && pending_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: files.f
rtl/cawm_pkg.sv
rtl/cawm_front.sv
rtl/cawm_queue.sv
rtl/cawm_back.sv
rtl/command_ack_window_matcher_top.sv
dv/command_ack_window_matcher_top_tb.sv
